// File: design/fdw_pkg.sv
// ----------------------------------------------------------------------------
// fdw_pkg
// Shared types and codes for the FIFO dispatcher.
// ----------------------------------------------------------------------------
package fdw_pkg;

  localparam int unsigned REQ_TYPE_W  = 2;
  localparam int unsigned REQ_ID_W    = 16;
  localparam int unsigned WORKER_ID_W = 5;
  localparam int unsigned STATUS_W    = 3;

  localparam logic [WORKER_ID_W-1:0] WORKER_COUNT_RST = 5'd16;

  localparam logic [REQ_TYPE_W-1:0] REQ_JOIN    = 2'd0;
  localparam logic [REQ_TYPE_W-1:0] REQ_SERVE   = 2'd1;
  localparam logic [REQ_TYPE_W-1:0] REQ_RELEASE = 2'd2;
  localparam logic [REQ_TYPE_W-1:0] REQ_NONE    = 2'd3;

  typedef enum logic [STATUS_W-1:0] {
    ST_JOINED       = 3'd0,
    ST_SERVED       = 3'd1,
    ST_EMPTY        = 3'd2,
    ST_NO_WORKER    = 3'd3,
    ST_RELEASED     = 3'd4,
    ST_ALREADY_FREE = 3'd5,
    ST_UNKNOWN      = 3'd6,
    ST_FULL         = 3'd7
  } status_e;

  typedef struct packed {
    logic [REQ_TYPE_W-1:0]  kind;
    logic [REQ_ID_W-1:0]    rid;
    logic [WORKER_ID_W-1:0] wid;
  } req_t;

endpackage

// File: design/fifo_dispatch_to_free_worker_top.sv
// ----------------------------------------------------------------------------
// fifo_dispatch_to_free_worker_top
// Requester FIFO with dispatch to the lowest-numbered free worker.
// Request captured when idle (queue RAM read), result registered in update;
// a NONE request gives no result. No new request is taken until back in idle.
// A stalled result holds the update stage until the output is taken.
// Reset: queue empty, all workers free, worker count 16; RAM is not cleared.
// ----------------------------------------------------------------------------
module fifo_dispatch_to_free_worker_top #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned MAX_WORKERS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [fdw_pkg::WORKER_ID_W-1:0]   cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [fdw_pkg::REQ_TYPE_W-1:0]    req_type_i,
  input  logic [fdw_pkg::REQ_ID_W-1:0]      requester_id_i,
  input  logic [fdw_pkg::WORKER_ID_W-1:0]   worker_id_in_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [fdw_pkg::STATUS_W-1:0]      status_o,
  output logic [fdw_pkg::WORKER_ID_W-1:0]   worker_id_out_o,
  output logic [fdw_pkg::REQ_ID_W-1:0]      served_id_o
);
  import fdw_pkg::*;

  localparam int unsigned PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned FILL_W = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned WSEL_W = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;

  localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(QUEUE_DEPTH);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic                   state_q, state_d;
  req_t                   req_q;
  logic [REQ_ID_W-1:0]    ids_mem [QUEUE_DEPTH];
  logic [REQ_ID_W-1:0]    rd_q;
  logic [PTR_W-1:0]       head_q, head_d, tail_q, tail_d;
  logic [FILL_W-1:0]      fill_q, fill_d;
  logic [MAX_WORKERS-1:0] busy_q, busy_d;
  logic [WORKER_ID_W-1:0] count_q;
  logic                   out_valid_q, out_valid_d;
  status_e                status_q, status_d;
  logic [WORKER_ID_W-1:0] wout_q, wout_d;
  logic [REQ_ID_W-1:0]    sid_q, sid_d;
  logic                   mem_we;
  logic                   in_accept, exec_go;
  logic [MAX_WORKERS-1:0] elig;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && (state_q == S_IDLE);
  assign exec_go    = (state_q == S_EXEC) && (!out_valid_q || !out_stall_i);

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign worker_id_out_o = wout_q;
  assign served_id_o     = sid_q;

  // workers 1..min(count, MAX_WORKERS)
  always_comb begin
    for (int i = 0; i < MAX_WORKERS; i++) begin
      elig[i] = ({27'd0, count_q} > 32'(i));
    end
  end

  always_comb begin
    logic                   found;
    logic [WSEL_W-1:0]      idx;
    logic [MAX_WORKERS-1:0] free;
    logic                   rel_ok;
    logic [WSEL_W-1:0]      rel_idx;
    found    = 1'b0;
    idx      = '0;
    free     = ~busy_q & elig;
    rel_ok   = (req_q.wid != '0) && ({27'd0, req_q.wid} <= 32'(MAX_WORKERS)) &&
               (req_q.wid <= count_q);
    rel_idx  = WSEL_W'(32'(req_q.wid) - 32'd1);
    for (int i = MAX_WORKERS - 1; i >= 0; i--) begin
      if (free[i]) begin
        found = 1'b1;
        idx   = WSEL_W'(i);
      end
    end

    state_d     = state_q;
    head_d      = head_q;
    tail_d      = tail_q;
    fill_d      = fill_q;
    busy_d      = busy_q;
    mem_we      = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;
    status_d    = status_q;
    wout_d      = wout_q;
    sid_d       = sid_q;

    if (in_accept) begin
      state_d = S_EXEC;
    end

    if (exec_go) begin
      state_d     = S_IDLE;
      out_valid_d = 1'b1;
      wout_d      = '0;
      sid_d       = '0;
      unique case (req_q.kind)
        REQ_JOIN: begin
          if (fill_q == FILL_MAX) begin
            status_d = ST_FULL;
          end else begin
            mem_we   = 1'b1;
            tail_d   = (tail_q == PTR_LAST) ? '0 : tail_q + 1'b1;
            fill_d   = fill_q + 1'b1;
            status_d = ST_JOINED;
          end
        end
        REQ_SERVE: begin
          if (fill_q == '0) begin
            status_d = ST_EMPTY;
          end else if (!found) begin
            status_d = ST_NO_WORKER;
          end else begin
            busy_d[idx] = 1'b1;
            head_d      = (head_q == PTR_LAST) ? '0 : head_q + 1'b1;
            fill_d      = fill_q - 1'b1;
            sid_d       = rd_q;
            wout_d      = WORKER_ID_W'(32'(idx) + 32'd1);
            status_d    = ST_SERVED;
          end
        end
        REQ_RELEASE: begin
          if (!rel_ok) begin
            status_d = ST_UNKNOWN;
          end else begin
            wout_d = req_q.wid;
            if (busy_q[rel_idx]) begin
              busy_d[rel_idx] = 1'b0;
              status_d        = ST_RELEASED;
            end else begin
              status_d = ST_ALREADY_FREE;
            end
          end
        end
        default: begin
          out_valid_d = out_valid_q && out_stall_i;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      fill_q      <= '0;
      busy_q      <= '0;
      count_q     <= WORKER_COUNT_RST;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      fill_q      <= fill_d;
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        count_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      req_q.kind <= req_type_i;
      req_q.rid  <= requester_id_i;
      req_q.wid  <= worker_id_in_i;
    end
    status_q <= status_d;
    wout_q   <= wout_d;
    sid_q    <= sid_d;
  end

  // queue RAM: head read on accept, tail write in the update cycle
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      rd_q <= ids_mem[head_q];
    end
    if (mem_we) begin
      ids_mem[tail_q] <= req_q.rid;
    end
  end

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FILL_MAX)
    else $error("fill count beyond queue depth");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q != '0 && fill_q != FILL_MAX) |-> (head_q != tail_q))
    else $error("pointers meet with partial fill");

  a_out_from_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_EXEC))
    else $error("result raised outside update cycle");

  a_served_worker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && status_q == ST_SERVED) |-> (wout_q != '0))
    else $error("serve without worker");

endmodule
